>>> sv/dht_pkg.sv
// shared types, codes and helpers for the double hashing key/value table
// no dependencies
`timescale 1ns / 1ps

package dht_pkg;

    localparam int KEY_W   = 31;
    localparam int VAL_W   = 32;
    localparam int SIZE_W  = 9;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 9'd101;
    localparam int                SIZE_MAX         = 511;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LIMIT   = 2'd2;

    // remainder unit: dividend bits handled per cycle and cycle counts
    localparam int DIVD_W         = 32;
    localparam int BITS_PER_CYCLE = 4;
    localparam int CNT_W          = 4;
    localparam int SUM_W          = 12;
    localparam logic [CNT_W-1:0] KEY_CYCLES  = CNT_W'(DIVD_W / BITS_PER_CYCLE);
    localparam logic [CNT_W-1:0] STEP_CYCLES = CNT_W'(SUM_W / BITS_PER_CYCLE);

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] value_out;
        logic [SIZE_W-1:0]       probe_count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_STEP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load_item;
        logic start_key;
        logic start_step;
        logic slot_load;
        logic mem_read;
        logic inc_count;
        logic set_limit;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic in_cmd_ok;
        logic mod_done;
        logic hit_stop;
        logic limit;
        logic out_free;
    } dp_stat_t;

    // x mod 3 by summing base-4 digits
    function automatic logic [1:0] mod3(input logic [SIZE_W-1:0] x);
        logic [3:0] acc;
        logic [2:0] r;
        acc = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]) + 4'(x[8]);
        r   = 3'(acc[1:0]) + 3'(acc[3:2]);
        if (r >= 3'd3) r = r - 3'd3;
        if (r >= 3'd3) r = r - 3'd3;
        return r[1:0];
    endfunction

endpackage

>>> sv/dht_mod_unit.sv
// iterative remainder unit, BITS_PER_CYCLE dividend bits per cycle
// depends on dht_pkg
`timescale 1ns / 1ps

module dht_mod_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [dht_pkg::DIVD_W-1:0]   dividend,
    input  logic [dht_pkg::CNT_W-1:0]    cycles,
    input  logic [dht_pkg::SIZE_W-1:0]   divisor,
    output logic [dht_pkg::SIZE_W-1:0]   rem,
    output logic                         done
);

    logic [dht_pkg::DIVD_W-1:0] sh_reg, sh_next;
    logic [dht_pkg::SIZE_W-1:0] rem_reg, rem_next;
    logic [dht_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       done_reg, done_next;

    always_comb
    begin
        logic [dht_pkg::SIZE_W:0]   t;
        logic [dht_pkg::SIZE_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < dht_pkg::BITS_PER_CYCLE; i++)
        begin
            t = {r, sh_reg[dht_pkg::DIVD_W-1-i]};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            r = t[dht_pkg::SIZE_W-1:0];
        end
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next  = dividend;
            rem_next = '0;
            cnt_next = cycles;
        end
        else if (cnt_reg != '0)
        begin
            sh_next   = sh_reg << dht_pkg::BITS_PER_CYCLE;
            rem_next  = r;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == dht_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

>>> sv/dht_datapath.sv
// slot memories, probe registers, result register and clearing counter
// depends on dht_pkg and dht_mod_unit
`timescale 1ns / 1ps

module dht_datapath #(
    parameter int CAPACITY = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [dht_pkg::SIZE_W-1:0]  table_size,
    input  dht_pkg::req_t               req,
    input  dht_pkg::dp_cmd_t            cmd,
    output dht_pkg::dp_stat_t           stat,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output dht_pkg::rsp_t               rsp
);

    localparam int AW        = $clog2(CAPACITY);
    localparam int CAP_CLAMP = (CAPACITY < dht_pkg::SIZE_MAX) ? CAPACITY : dht_pkg::SIZE_MAX;
    localparam int KW        = dht_pkg::KEY_W + 1;

    logic [KW-1:0]            key_mem [CAPACITY];
    logic [dht_pkg::VAL_W-1:0] val_mem [CAPACITY];

    dht_pkg::req_t              item_reg;
    logic [dht_pkg::SIZE_W-1:0] slot_reg;
    logic [dht_pkg::SIZE_W-1:0] cnt_reg;
    logic                       lim_reg;
    logic [AW-1:0]              clr_reg;
    logic [KW-1:0]              krd_reg;
    logic [dht_pkg::VAL_W-1:0]  vrd_reg;
    logic                       rsp_valid_reg;
    dht_pkg::rsp_t              rsp_reg, rsp_next;

    logic [dht_pkg::SIZE_W-1:0] size_lo, n_eff;
    logic [dht_pkg::SIZE_W-1:0] cnt_inc;
    logic [dht_pkg::SUM_W-1:0]  step_sum;
    logic [1:0]                 stride;
    logic                       used, key_hit, cmd_ok, out_free;
    logic                       mod_start, mod_done;
    logic [dht_pkg::DIVD_W-1:0] mod_divd;
    logic [dht_pkg::CNT_W-1:0]  mod_cycles;
    logic [dht_pkg::SIZE_W-1:0] mod_rem;
    logic                       kwr_en, vwr_en;
    logic [AW-1:0]              wr_addr;
    logic [KW-1:0]              kwr_data;

    // effective size clamped to 2..min(capacity, SIZE_MAX)
    always_comb
    begin
        size_lo = (table_size < 9'd2) ? 9'd2 : table_size;
        n_eff   = (32'(size_lo) > CAP_CLAMP) ? dht_pkg::SIZE_W'(CAP_CLAMP) : size_lo;
    end

    assign cnt_inc  = cnt_reg + 1'b1;
    assign stride   = 2'd3 - dht_pkg::mod3(slot_reg);
    assign step_sum = dht_pkg::SUM_W'(slot_reg)
                    + dht_pkg::SUM_W'(cnt_inc) * dht_pkg::SUM_W'(stride);

    assign mod_start  = cmd.start_key | cmd.start_step;
    assign mod_divd   = cmd.start_key ? {1'b0, req.key}
                                      : {step_sum, (dht_pkg::DIVD_W - dht_pkg::SUM_W)'(0)};
    assign mod_cycles = cmd.start_key ? dht_pkg::KEY_CYCLES : dht_pkg::STEP_CYCLES;

    dht_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_divd),
        .cycles   (mod_cycles),
        .divisor  (n_eff),
        .rem      (mod_rem),
        .done     (mod_done)
    );

    assign used     = krd_reg[KW-1];
    assign key_hit  = (krd_reg[dht_pkg::KEY_W-1:0] == item_reg.key);
    assign cmd_ok   = (item_reg.command == dht_pkg::CMD_INSERT)
                   || (item_reg.command == dht_pkg::CMD_REMOVE)
                   || (item_reg.command == dht_pkg::CMD_FIND);
    assign out_free = !rsp_valid_reg || rsp_ready;

    assign stat.clear_last = (clr_reg == AW'(CAPACITY - 1));
    assign stat.in_cmd_ok  = (req.command == dht_pkg::CMD_INSERT)
                          || (req.command == dht_pkg::CMD_REMOVE)
                          || (req.command == dht_pkg::CMD_FIND);
    assign stat.mod_done   = mod_done;
    assign stat.hit_stop   = !used || key_hit;
    assign stat.limit      = (cnt_inc >= n_eff);
    assign stat.out_free   = out_free;

    // clearing writes, and table update and result on commit
    always_comb
    begin
        kwr_en   = 1'b0;
        vwr_en   = 1'b0;
        wr_addr  = AW'(slot_reg);
        kwr_data = {1'b1, item_reg.key};
        rsp_next.status      = dht_pkg::STAT_OK;
        rsp_next.value_out   = '0;
        rsp_next.probe_count = cnt_reg;
        if (cmd.clear_wr)
        begin
            kwr_en   = 1'b1;
            wr_addr  = clr_reg;
            kwr_data = '0;
        end
        else if (cmd.commit && cmd_ok)
        begin
            if (lim_reg)
            begin
                rsp_next.status = dht_pkg::STAT_LIMIT;
            end
            else if (item_reg.command == dht_pkg::CMD_INSERT)
            begin
                kwr_en = 1'b1;
                vwr_en = 1'b1;
            end
            else if (!used)
            begin
                rsp_next.status = dht_pkg::STAT_MISSING;
            end
            else if (item_reg.command == dht_pkg::CMD_REMOVE)
            begin
                kwr_en   = 1'b1;
                kwr_data = {1'b0, item_reg.key};
            end
            else
            begin
                rsp_next.value_out = vrd_reg;
            end
        end
        else if (cmd.commit)
        begin
            rsp_next.probe_count = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kwr_en)
        begin
            key_mem[wr_addr] <= kwr_data;
        end
        if (vwr_en)
        begin
            val_mem[wr_addr] <= item_reg.value;
        end
        if (cmd.mem_read)
        begin
            krd_reg <= key_mem[AW'(slot_reg)];
            vrd_reg <= val_mem[AW'(slot_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            cnt_reg       <= '0;
            lim_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load_item)
            begin
                cnt_reg <= '0;
                lim_reg <= 1'b0;
            end
            else
            begin
                if (cmd.inc_count)
                begin
                    cnt_reg <= cnt_inc;
                end
                if (cmd.set_limit)
                begin
                    lim_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
        if (cmd.slot_load)
        begin
            slot_reg <= mod_rem;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_read |-> (slot_reg < n_eff))
        else $error("probe slot outside the table");

    rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (mod_rem < n_eff))
        else $error("remainder not reduced");

    no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("result register overwritten");

    // the size may be rewritten between commands, so check only at commit
    count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && lim_reg) |-> (cnt_reg == n_eff))
        else $error("probe limit without full count");

endmodule

>>> sv/dht_ctrl.sv
// controller state machine: clearing pass, hashing, probe loop, result
// depends on dht_pkg
`timescale 1ns / 1ps

module dht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dht_pkg::dp_stat_t stat,
    output dht_pkg::dp_cmd_t  cmd
);

    dht_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dht_pkg::S_CLEAR:
            begin
                if (stat.clear_last) state_next = dht_pkg::S_IDLE;
            end
            dht_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = stat.in_cmd_ok ? dht_pkg::S_HASH : dht_pkg::S_FINISH;
                end
            end
            dht_pkg::S_HASH:
            begin
                if (stat.mod_done) state_next = dht_pkg::S_READ;
            end
            dht_pkg::S_READ:
            begin
                state_next = dht_pkg::S_CHECK;
            end
            dht_pkg::S_CHECK:
            begin
                if (stat.hit_stop || stat.limit) state_next = dht_pkg::S_FINISH;
                else                             state_next = dht_pkg::S_STEP;
            end
            dht_pkg::S_STEP:
            begin
                if (stat.mod_done) state_next = dht_pkg::S_READ;
            end
            dht_pkg::S_FINISH:
            begin
                if (stat.out_free) state_next = dht_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dht_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            dht_pkg::S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            dht_pkg::S_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.load_item = req_valid;
                cmd.start_key = req_valid && stat.in_cmd_ok;
            end
            dht_pkg::S_HASH,
            dht_pkg::S_STEP:
            begin
                cmd.slot_load = stat.mod_done;
            end
            dht_pkg::S_READ:
            begin
                cmd.mem_read = 1'b1;
            end
            dht_pkg::S_CHECK:
            begin
                // collision: count it, then stop at the limit or compute the next slot
                if (!stat.hit_stop)
                begin
                    cmd.inc_count  = 1'b1;
                    cmd.set_limit  = stat.limit;
                    cmd.start_step = !stat.limit;
                end
            end
            dht_pkg::S_FINISH:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dht_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    one_start: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.start_key && cmd.start_step))
        else $error("remainder unit started twice");

    read_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.slot_load |=> cmd.mem_read)
        else $error("slot loaded without a read");

    commit_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !cmd.commit)
        else $error("item committed twice");

endmodule

>>> sv/double_hash_table_mod_prime_top.sv
// per command, the key remainder is computed in the shared remainder unit, and each
//   further probe takes another remainder there plus one registered memory read and a compare
// throughput: one command at a time; the next is taken once the result is registered
// reset: table_size returns to 101, then a clearing pass over the CAPACITY slots empties
//   every slot while no command is taken
// top level of the double hashing key/value table
// depends on dht_pkg, dht_ctrl and dht_datapath
`timescale 1ns / 1ps

module double_hash_table_mod_prime_top #(
    parameter int CAPACITY = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  dht_pkg::req_t               cmd_data,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output dht_pkg::rsp_t               rsp_data,
    input  logic                        cfg_wr_en,
    input  logic [dht_pkg::SIZE_W-1:0]  cfg_wr_data
);

    logic [dht_pkg::SIZE_W-1:0] table_size_reg;
    dht_pkg::dp_cmd_t           dp_cmd;
    dht_pkg::dp_stat_t          dp_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= dht_pkg::TABLE_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            table_size_reg <= cfg_wr_data;
        end
    end

    dht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (cmd_valid),
        .req_ready (cmd_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    dht_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .table_size (table_size_reg),
        .req        (cmd_data),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp_data)
    );

endmodule
